// ----- design/banded_edit_distance_defines.svh -----
// Assertion helpers shared by the checker files.
`ifndef BANDED_EDIT_DISTANCE_DEFINES_SVH
`define BANDED_EDIT_DISTANCE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define BED_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("banded edit distance check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define BED_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("banded edit distance check failed");

`endif

// ----- design/bed_pkg.sv -----
package bed_pkg;

  // Default sizes.
  localparam int DEF_MAX_LEN       = 256;
  localparam int DEF_MAX_THRESHOLD = 15;

  // Field widths.
  localparam int THR_W  = 4;
  localparam int VAL_W  = THR_W + 1;
  localparam int MODE_W = 2;
  localparam int SYM_W  = 8;

  // Word kinds on the input tuser.
  localparam logic [MODE_W-1:0] MODE_FIRST  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SECOND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_END    = 2'd2;

  // Register map.
  localparam int               PADDR_W          = 3;
  localparam logic [0:0]       REG_MAX_DISTANCE = 1'b0;
  localparam logic [THR_W-1:0] MAX_DIST_RESET   = 4'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FINISH
  } state_e;

  // Control shared by every cell of the band.
  typedef struct packed {
    logic             init;
    logic [THR_W-1:0] thr;
  } band_ctrl_t;

endpackage

// ----- design/banded_edit_distance.sv -----
// Channel   Dir  Contents
// s_axis    in   tdata: symbol[7:0]; tuser: mode[1:0]
// m_axis    out  tdata: within_res[0], distance[4:1], overflow[5], zero[7:6]
// apb       in   max_distance at byte address 0, pready always high
//
// First- and second-string words are taken back to back while the block is idle.
// An end word runs the band sweep on the row of 2*MAX_THRESHOLD+1 cells over
// the first string (t threshold), then the finish state registers the result;
// with a length gap above t the sweep is skipped and the finish state follows.
// Reset clears both lengths and the overflow flag and sets max_distance to 3;
// no memory clearing pass is run.
// The result waits in the output register while new string words are taken;
// the next end word holds in its finish state until that result is taken.
module banded_edit_distance #(
  parameter int MAX_LEN       = bed_pkg::DEF_MAX_LEN,
  parameter int MAX_THRESHOLD = bed_pkg::DEF_MAX_THRESHOLD
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // symbol[7:0]
  input  logic [7:0]                  s_axis_tdata_i,
  // mode[1:0]
  input  logic [1:0]                  s_axis_tuser_i,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // within_res[0], distance[4:1], overflow[5], zero[7:6]
  output logic [7:0]                  m_axis_tdata_o,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [bed_pkg::PADDR_W-1:0] paddr_i,
  input  logic [31:0]                 pwdata_i,
  output logic [31:0]                 prdata_o,
  output logic                        pready_o
);
  import bed_pkg::*;

  localparam int CNT_W  = $clog2(MAX_LEN + 1);
  localparam int AW     = $clog2(MAX_LEN);
  localparam int STEP_W = $clog2(2 * MAX_LEN + 2 * MAX_THRESHOLD + 2);
  localparam int DW     = $clog2(2 * MAX_THRESHOLD + 1);
  localparam int RW     = $clog2(MAX_LEN + 2 * MAX_THRESHOLD + 2);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  first_cnt_q;
  logic [CNT_W-1:0]  second_cnt_q;
  logic              trunc_q;
  logic              band_ok_q;
  logic [THR_W-1:0]  max_distance_q;
  logic [STEP_W-1:0] cnt_q;
  logic              m_valid_q;
  logic              out_within_q;
  logic [THR_W-1:0]  out_dist_q;
  logic              out_ovf_q;

  logic [SYM_W-1:0]  first_mem  [MAX_LEN];
  logic [SYM_W-1:0]  second_mem [MAX_LEN];
  logic [SYM_W-1:0]  a_rd_q;
  logic [SYM_W-1:0]  b_rd_q;

  logic              in_acc;
  logic              end_word;
  logic              in_band;
  logic              start_sweep;
  logic              out_load;
  logic              cfg_wr;
  logic [THR_W-1:0]  thr;
  logic [CNT_W-1:0]  len_diff;
  logic [STEP_W-1:0] last_step;
  logic [STEP_W-2:0] half;
  logic [AW-1:0]     rd_addr;
  logic              tok_valid;
  logic [DW-1:0]     res_sel;
  logic [VAL_W-1:0]  band_res;
  logic              res_within;
  band_ctrl_t        band_ctrl;

  // Decode handshakes and the effective threshold.
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign end_word        = in_acc && (s_axis_tuser_i == MODE_END);
  assign thr             = (32'(max_distance_q) > MAX_THRESHOLD) ?
                           THR_W'(MAX_THRESHOLD) : max_distance_q;
  assign len_diff        = (first_cnt_q > second_cnt_q) ? first_cnt_q - second_cnt_q :
                                                          second_cnt_q - first_cnt_q;
  assign in_band         = (len_diff <= CNT_W'(thr));
  assign last_step       = (STEP_W'(first_cnt_q) << 1) + (STEP_W'(thr) << 1);

  // Sequence load, sweep and result.
  always_comb begin
    state_d     = state_q;
    start_sweep = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (end_word) begin
          start_sweep = in_band;
          state_d     = in_band ? ST_SWEEP : ST_FINISH;
        end
      end
      ST_SWEEP: begin
        if (cnt_q == last_step) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!m_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold lengths, overflow, sweep step and output valid.
  assign cfg_wr = psel_i && penable_i && pwrite_i && pready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_cnt_q    <= '0;
      second_cnt_q   <= '0;
      trunc_q        <= 1'b0;
      band_ok_q      <= 1'b0;
      max_distance_q <= MAX_DIST_RESET;
      cnt_q          <= '0;
      m_valid_q      <= 1'b0;
    end else begin
      if (cfg_wr && paddr_i[PADDR_W-1:2] == REG_MAX_DISTANCE) begin
        max_distance_q <= pwdata_i[THR_W-1:0];
      end
      if (in_acc) begin
        case (s_axis_tuser_i)
          MODE_FIRST: begin
            if (first_cnt_q < CNT_W'(MAX_LEN)) first_cnt_q <= first_cnt_q + CNT_W'(1);
            else trunc_q <= 1'b1;
          end
          MODE_SECOND: begin
            if (second_cnt_q < CNT_W'(MAX_LEN)) second_cnt_q <= second_cnt_q + CNT_W'(1);
            else trunc_q <= 1'b1;
          end
          MODE_END: band_ok_q <= in_band;
          default: ;
        endcase
      end
      if (start_sweep) begin
        cnt_q <= '0;
      end else if (state_q == ST_SWEEP) begin
        cnt_q <= cnt_q + STEP_W'(1);
      end
      if (out_load) begin
        first_cnt_q  <= '0;
        second_cnt_q <= '0;
        trunc_q      <= 1'b0;
        m_valid_q    <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // String memories: write on load words, read a byte pair each sweep cycle.
  assign rd_addr = cnt_q[AW:1];

  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tuser_i == MODE_FIRST && first_cnt_q < CNT_W'(MAX_LEN)) begin
      first_mem[first_cnt_q[AW-1:0]] <= s_axis_tdata_i;
    end
    a_rd_q <= first_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tuser_i == MODE_SECOND && second_cnt_q < CNT_W'(MAX_LEN)) begin
      second_mem[second_cnt_q[AW-1:0]] <= s_axis_tdata_i;
    end
    b_rd_q <= second_mem[rd_addr];
  end

  // Inject row i on even step 2i.
  assign half      = cnt_q[STEP_W-1:1];
  assign tok_valid = (state_q == ST_SWEEP) && !cnt_q[0] && (half != '0) &&
                     (STEP_W'(half) <= STEP_W'(first_cnt_q));

  assign band_ctrl.init = start_sweep;
  assign band_ctrl.thr  = thr;
  assign res_sel        = DW'(RW'(second_cnt_q) + RW'(thr) - RW'(first_cnt_q));

  bed_band #(
    .MAX_LEN      (MAX_LEN),
    .MAX_THRESHOLD(MAX_THRESHOLD)
  ) u_band (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (band_ctrl),
    .m_i        (second_cnt_q),
    .tok_valid_i(tok_valid),
    .tok_idx_i  (CNT_W'(half)),
    .tok_sym_i  (a_rd_q),
    .bsym_i     (b_rd_q),
    .sel_i      (res_sel),
    .res_o      (band_res)
  );

  // Register the result word.
  assign res_within = band_ok_q && (band_res <= {1'b0, thr});

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_within_q <= res_within;
      out_dist_q   <= res_within ? band_res[THR_W-1:0] : '0;
      out_ovf_q    <= trunc_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_ovf_q, out_dist_q, out_within_q};

  // Register read-back.
  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i[PADDR_W-1:2] == REG_MAX_DISTANCE) ?
                    {{(32 - THR_W){1'b0}}, max_distance_q} : 32'd0;

endmodule

// ----- design/bed_cell.sv -----
module bed_cell #(
  parameter int MAX_LEN       = bed_pkg::DEF_MAX_LEN,
  parameter int MAX_THRESHOLD = bed_pkg::DEF_MAX_THRESHOLD,
  parameter int CELL_IDX      = 0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bed_pkg::band_ctrl_t          ctrl_i,
  input  logic [$clog2(MAX_LEN+1)-1:0] m_i,
  input  logic                         tok_valid_i,
  input  logic [$clog2(MAX_LEN+1)-1:0] tok_idx_i,
  input  logic [bed_pkg::SYM_W-1:0]    tok_sym_i,
  output logic                         tok_valid_o,
  output logic [$clog2(MAX_LEN+1)-1:0] tok_idx_o,
  output logic [bed_pkg::SYM_W-1:0]    tok_sym_o,
  input  logic [bed_pkg::SYM_W-1:0]    bsym_i,
  output logic [bed_pkg::SYM_W-1:0]    bsym_o,
  input  logic [bed_pkg::VAL_W-1:0]    left_i,
  input  logic [bed_pkg::VAL_W-1:0]    up_i,
  output logic [bed_pkg::VAL_W-1:0]    val_o
);
  import bed_pkg::*;

  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int SW    = $clog2(MAX_LEN + 2 * MAX_THRESHOLD + 2) + 1;

  logic             tok_valid_q;
  logic [CNT_W-1:0] tok_idx_q;
  logic [SYM_W-1:0] tok_sym_q;
  logic [SYM_W-1:0] bsym_q;
  logic [VAL_W-1:0] val_q;
  logic [VAL_W-1:0] val_d;
  logic [VAL_W-1:0] cap;
  logic [VAL_W-1:0] row0;
  logic [VAL_W-1:0] diag;
  logic [VAL_W-1:0] best;
  logic [VAL_W-1:0] up_inc;
  logic [VAL_W-1:0] left_inc;
  logic [SW-1:0]    sum_id;
  logic [SW-1:0]    thr_s;
  logic [SW-1:0]    m_thr;
  logic [SW-1:0]    band_w;
  logic             active;

  function automatic logic [VAL_W-1:0] sat_inc(input logic [VAL_W-1:0] v,
                                               input logic [VAL_W-1:0] c);
    return (v >= c) ? c : v + VAL_W'(1);
  endfunction

  assign cap    = {1'b0, ctrl_i.thr} + VAL_W'(1);
  assign thr_s  = SW'(ctrl_i.thr);
  assign m_thr  = SW'(m_i) + thr_s;
  assign band_w = thr_s << 1;
  assign sum_id = SW'(tok_idx_i) + SW'(CELL_IDX);
  assign active = tok_valid_i && (SW'(CELL_IDX) <= band_w);

  // Row zero: column d - t, capped outside the second string's range.
  always_comb begin
    if (SW'(CELL_IDX) < thr_s || SW'(CELL_IDX) > m_thr) begin
      row0 = cap;
    end else begin
      row0 = VAL_W'(SW'(CELL_IDX) - thr_s);
    end
  end

  // One band entry of the current row from diagonal, up and left.
  always_comb begin
    up_inc   = sat_inc(up_i, cap);
    left_inc = sat_inc(left_i, cap);
    diag     = (tok_sym_i != bsym_i) ? sat_inc(val_q, cap) : val_q;
    best     = diag;
    if (SW'(CELL_IDX) < band_w && up_inc < best) begin
      best = up_inc;
    end
    if (CELL_IDX > 0 && left_inc < best) begin
      best = left_inc;
    end
    if (sum_id < thr_s || sum_id > m_thr) begin
      val_d = cap;
    end else if (sum_id == thr_s) begin
      val_d = (SW'(tok_idx_i) > SW'(cap)) ? cap : VAL_W'(tok_idx_i);
    end else begin
      val_d = best;
    end
  end

  // Advance the row token one cell to the right; drop leftovers when a sweep starts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else if (ctrl_i.init) begin
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_idx_q <= tok_idx_i;
    tok_sym_q <= tok_sym_i;
    bsym_q    <= bsym_i;
    if (ctrl_i.init) begin
      val_q <= row0;
    end else if (active) begin
      val_q <= val_d;
    end
  end

  assign tok_valid_o = tok_valid_q;
  assign tok_idx_o   = tok_idx_q;
  assign tok_sym_o   = tok_sym_q;
  assign bsym_o      = bsym_q;
  assign val_o       = val_q;

endmodule

// ----- design/bed_band.sv -----
module bed_band #(
  parameter int MAX_LEN       = bed_pkg::DEF_MAX_LEN,
  parameter int MAX_THRESHOLD = bed_pkg::DEF_MAX_THRESHOLD
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  bed_pkg::band_ctrl_t                    ctrl_i,
  input  logic [$clog2(MAX_LEN+1)-1:0]           m_i,
  input  logic                                   tok_valid_i,
  input  logic [$clog2(MAX_LEN+1)-1:0]           tok_idx_i,
  input  logic [bed_pkg::SYM_W-1:0]              tok_sym_i,
  input  logic [bed_pkg::SYM_W-1:0]              bsym_i,
  input  logic [$clog2(2*MAX_THRESHOLD+1)-1:0]   sel_i,
  output logic [bed_pkg::VAL_W-1:0]              res_o
);
  import bed_pkg::*;

  localparam int BAND  = 2 * MAX_THRESHOLD + 1;
  localparam int CNT_W = $clog2(MAX_LEN + 1);

  logic [VAL_W-1:0] val_w   [BAND];
  logic             tv_w    [BAND];
  logic [CNT_W-1:0] ti_w    [BAND];
  logic [SYM_W-1:0] ts_w    [BAND];
  logic [SYM_W-1:0] bs_w    [BAND];
  logic [SYM_W-1:0] bin_w   [BAND];
  logic [VAL_W-1:0] left_w  [BAND];
  logic [VAL_W-1:0] up_w    [BAND];
  logic             tvin_w  [BAND];
  logic [CNT_W-1:0] tiin_w  [BAND];
  logic [SYM_W-1:0] tsin_w  [BAND];

  for (genvar k = 0; k < BAND; k++) begin : g_cell
    // Row tokens enter at the left end, second-string bytes at cell 2t.
    if (k == 0) begin : g_head
      assign tvin_w[k] = tok_valid_i;
      assign tiin_w[k] = tok_idx_i;
      assign tsin_w[k] = tok_sym_i;
      assign left_w[k] = '0;
    end else begin : g_body
      assign tvin_w[k] = tv_w[k-1];
      assign tiin_w[k] = ti_w[k-1];
      assign tsin_w[k] = ts_w[k-1];
      assign left_w[k] = val_w[k-1];
    end
    if (k == BAND - 1) begin : g_tail
      assign up_w[k]  = '0;
      assign bin_w[k] = bsym_i;
    end else begin : g_mid
      assign up_w[k]  = val_w[k+1];
      assign bin_w[k] = (int'(ctrl_i.thr) * 2 == k) ? bsym_i : bs_w[k+1];
    end

    bed_cell #(
      .MAX_LEN      (MAX_LEN),
      .MAX_THRESHOLD(MAX_THRESHOLD),
      .CELL_IDX     (k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl_i),
      .m_i        (m_i),
      .tok_valid_i(tvin_w[k]),
      .tok_idx_i  (tiin_w[k]),
      .tok_sym_i  (tsin_w[k]),
      .tok_valid_o(tv_w[k]),
      .tok_idx_o  (ti_w[k]),
      .tok_sym_o  (ts_w[k]),
      .bsym_i     (bin_w[k]),
      .bsym_o     (bs_w[k]),
      .left_i     (left_w[k]),
      .up_i       (up_w[k]),
      .val_o      (val_w[k])
    );
  end

  // Pick the band entry that lands on the last column.
  assign res_o = val_w[sel_i];

endmodule

// ----- design/bed_checker.sv -----
`include "banded_edit_distance_defines.svh"

module bed_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic [1:0] s_axis_tuser_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i
);
  import bed_pkg::*;

  // A stalled result word stays offered and unchanged.
  `BED_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o)
  `BED_ASSERT_NEXT(a_out_stable, m_axis_tvalid_o && !m_axis_tready_i, $stable(m_axis_tdata_o))

  // An end word closes the input while the pair is compared.
  `BED_ASSERT_NEXT(a_end_busy, s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i == MODE_END, !s_axis_tready_o)

  // A string byte never causes a new result word.
  `BED_ASSERT_NEXT(a_load_quiet, s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i != MODE_END, !$rose(m_axis_tvalid_o))

endmodule

bind banded_edit_distance bed_checker u_bed_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .s_axis_tuser_i (s_axis_tuser_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i)
);
